/* hw/rtl/tls_record_covert_bit_decoder_defines.svh */
// ----------------------------------------------------------------------------
// tls record covert bit decoder: assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef TLS_RECORD_COVERT_BIT_DECODER_DEFINES_SVH
`define TLS_RECORD_COVERT_BIT_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TLSRCB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tlsrcb: same-cycle check failed");

// next-cycle implication, checked outside reset
`define TLSRCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tlsrcb: next-cycle check failed");

`endif

/* hw/rtl/tlsrcb_pkg.sv */
// ----------------------------------------------------------------------------
// tlsrcb_pkg
// constants, types and codes of the tls record covert bit decoder
// ----------------------------------------------------------------------------
package tlsrcb_pkg;

	// record content types
	localparam logic [7:0] REC_ALERT = 8'd21;
	localparam logic [7:0] REC_DATA  = 8'd23;

	// length channel symbols
	localparam logic [15:0] LEN_ZERO = 16'd64;
	localparam logic [15:0] LEN_ONE  = 16'd80;

	// bit counts and type channel run handling
	localparam logic [2:0] STUFF_RUN = 3'd4;
	localparam logic [2:0] RUN_MAX   = 3'd5;
	localparam logic [3:0] BYTE_BITS = 4'd8;
	localparam logic [2:0] LEN_LAST  = 3'd7;

	// keystream generator
	localparam logic [31:0] LCG_MUL = 32'd1103515245;
	localparam logic [31:0] LCG_ADD = 32'd12345;
	localparam logic [1:0]  LCG_LAST_STEP = 2'd2;

	// configuration register indexes
	localparam logic CFG_LEN_SEED = 1'b0;
	localparam logic CFG_TYP_SEED = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_FOLD,
		ST_DONE
	} state_t;

	typedef enum logic {
		CH_LEN,
		CH_TYP
	} chan_t;

	// per-record result of the bit channels
	typedef struct packed {
		logic       need_len;
		logic [7:0] len_raw;
		logic       need_typ;
		logic [7:0] typ_raw;
	} bits_res_t;

endpackage

/* hw/rtl/tls_record_covert_bit_decoder.sv */
// ----------------------------------------------------------------------------
// tls_record_covert_bit_decoder
// recovers the record length and content type covert byte streams
// ----------------------------------------------------------------------------
// Each input beat is one TLS record (content type, payload length) or a
// restart; each gives exactly one output beat with the two channel bytes and
// their flags. No new record is taken until the current one is through; the
// single shared multiply-add unit runs the keystream for each channel that
// completes a byte, the two channels taking turns on that unit. Every
// keystream byte needs three dependent generator steps, then a fold of the
// result back into its generator. A finished result sits in the output
// register, so the next record can be accepted while the downstream side
// still stalls. Seed writes take effect at the next restart beat.
// ----------------------------------------------------------------------------
module tls_record_covert_bit_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// input records
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] record_type, [23:8] record_length
	input  logic        s_tuser,   // [0] restart
	// decoded bytes
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] length_byte, [15:8] type_byte
	output logic [1:0]  m_tuser,   // [0] length_byte_valid, [1] type_byte_valid
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	tlsrcb_pkg::state_t    state_q, state_d;
	tlsrcb_pkg::chan_t     chan_q;
	tlsrcb_pkg::bits_res_t bits_res;

	// seeds and generator states
	logic [31:0] len_seed_q;
	logic [31:0] typ_seed_q;
	logic [31:0] len_gen_q;
	logic [31:0] typ_gen_q;

	// result under construction
	logic       len_valid_q;
	logic       typ_valid_q;
	logic [7:0] len_byte_q;
	logic [7:0] typ_byte_q;
	logic [1:0] step_q;

	// output register
	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	logic        in_beat;
	logic        need_any;
	logic        lcg_load;
	logic        lcg_sel_typ;
	logic        lcg_step;
	logic        out_load;
	logic [31:0] lcg_load_val;
	logic [31:0] lcg_acc;
	logic [7:0]  key_byte;

	assign in_beat  = s_tvalid && s_tready;
	assign need_any = bits_res.need_len || bits_res.need_typ;
	assign key_byte = lcg_acc[23:16];

	tlsrcb_bits u_bits (
		.clk           (clk),
		.arst_n        (arst_n),
		.upd           (in_beat),
		.restart       (s_tuser),
		.record_type   (s_tdata[7:0]),
		.record_length (s_tdata[23:8]),
		.res           (bits_res)
	);

	assign lcg_load_val = lcg_sel_typ ? typ_gen_q : len_gen_q;

	tlsrcb_lcg u_lcg (
		.clk      (clk),
		.load     (lcg_load),
		.load_val (lcg_load_val),
		.step     (lcg_step),
		.acc      (lcg_acc)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlsrcb_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (!s_tuser && need_any) begin
						state_d = tlsrcb_pkg::ST_STEP;
					end else begin
						state_d = tlsrcb_pkg::ST_DONE;
					end
				end
			end
			tlsrcb_pkg::ST_STEP: begin
				if (step_q == tlsrcb_pkg::LCG_LAST_STEP) begin
					state_d = tlsrcb_pkg::ST_FOLD;
				end
			end
			tlsrcb_pkg::ST_FOLD: begin
				if ((chan_q == tlsrcb_pkg::CH_LEN) && typ_valid_q) begin
					state_d = tlsrcb_pkg::ST_STEP;
				end else begin
					state_d = tlsrcb_pkg::ST_DONE;
				end
			end
			tlsrcb_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = tlsrcb_pkg::ST_IDLE;
				end
			end
			default: state_d = tlsrcb_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready    = 1'b0;
		lcg_load    = 1'b0;
		lcg_sel_typ = 1'b1;
		lcg_step    = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			tlsrcb_pkg::ST_IDLE: begin
				s_tready    = 1'b1;
				lcg_load    = s_tvalid && !s_tuser && need_any;
				lcg_sel_typ = !bits_res.need_len;
			end
			tlsrcb_pkg::ST_STEP: begin
				lcg_step = 1'b1;
			end
			tlsrcb_pkg::ST_FOLD: begin
				// second channel reuses the unit right after the first one
				lcg_load = (chan_q == tlsrcb_pkg::CH_LEN) && typ_valid_q;
			end
			tlsrcb_pkg::ST_DONE: begin
				out_load = !m_tvalid_q || m_tready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tlsrcb_pkg::ST_IDLE;
			chan_q      <= tlsrcb_pkg::CH_LEN;
			step_q      <= '0;
			len_seed_q  <= '0;
			typ_seed_q  <= '0;
			len_gen_q   <= '0;
			typ_gen_q   <= '0;
			len_valid_q <= 1'b0;
			typ_valid_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			// seed registers
			if (cfg_we) begin
				unique case (cfg_index)
					tlsrcb_pkg::CFG_LEN_SEED: len_seed_q <= cfg_data;
					tlsrcb_pkg::CFG_TYP_SEED: typ_seed_q <= cfg_data;
					default: ;
				endcase
			end

			if (in_beat) begin
				if (s_tuser) begin
					len_gen_q   <= len_seed_q;
					typ_gen_q   <= typ_seed_q;
					len_valid_q <= 1'b0;
					typ_valid_q <= 1'b0;
				end else begin
					len_valid_q <= bits_res.need_len;
					typ_valid_q <= bits_res.need_typ;
					chan_q      <= bits_res.need_len ? tlsrcb_pkg::CH_LEN : tlsrcb_pkg::CH_TYP;
				end
			end

			// generator step count
			if (lcg_load) begin
				step_q <= '0;
			end else if (lcg_step) begin
				step_q <= step_q + 2'd1;
			end

			// fold the finished keystream back into its generator
			if (state_q == tlsrcb_pkg::ST_FOLD) begin
				if (chan_q == tlsrcb_pkg::CH_LEN) begin
					len_gen_q <= lcg_acc;
					chan_q    <= tlsrcb_pkg::CH_TYP;
				end else begin
					typ_gen_q <= lcg_acc;
				end
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result bytes, cleared unless the channel completed
	always_ff @(posedge clk) begin
		if (in_beat) begin
			if (s_tuser) begin
				len_byte_q <= '0;
				typ_byte_q <= '0;
			end else begin
				len_byte_q <= bits_res.need_len ? bits_res.len_raw : 8'd0;
				typ_byte_q <= bits_res.need_typ ? bits_res.typ_raw : 8'd0;
			end
		end else if (state_q == tlsrcb_pkg::ST_FOLD) begin
			if (chan_q == tlsrcb_pkg::CH_LEN) begin
				len_byte_q <= len_byte_q ^ key_byte;
			end else begin
				typ_byte_q <= typ_byte_q ^ key_byte;
			end
		end
		if (out_load) begin
			m_tdata_q <= {typ_byte_q, len_byte_q};
			m_tuser_q <= {typ_valid_q, len_valid_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* hw/rtl/tlsrcb_lcg.sv */
// ----------------------------------------------------------------------------
// tlsrcb_lcg
// shared multiply-add unit that steps one keystream generator state
// ----------------------------------------------------------------------------
module tlsrcb_lcg (
	input  logic        clk,
	input  logic        load,
	input  logic [31:0] load_val,
	input  logic        step,
	output logic [31:0] acc
);

	logic [31:0] acc_q;
	logic [31:0] prod;

	assign prod = acc_q * tlsrcb_pkg::LCG_MUL;

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q <= load_val;
		end else if (step) begin
			acc_q <= prod + tlsrcb_pkg::LCG_ADD;
		end
	end

	assign acc = acc_q;

endmodule

/* hw/rtl/tlsrcb_bits.sv */
// ----------------------------------------------------------------------------
// tlsrcb_bits
// bit gathering state of the length and content type channels
// ----------------------------------------------------------------------------
module tlsrcb_bits (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  upd,
	input  logic                  restart,
	input  logic [7:0]            record_type,
	input  logic [15:0]           record_length,
	output tlsrcb_pkg::bits_res_t res
);

	logic [2:0] len_cnt_q;
	logic [7:0] len_shift_q;
	logic [3:0] typ_cnt_q;
	logic [7:0] typ_shift_q;
	logic [2:0] run_q;

	logic       is_data;
	logic       is_alert;
	logic       len_hit;
	logic       len_bit;
	logic [7:0] len_next;
	logic       len_done;
	logic       typ_take;
	logic [2:0] typ_pos;
	logic [7:0] typ_next;
	logic       typ_done;

	assign is_data  = (record_type == tlsrcb_pkg::REC_DATA);
	assign is_alert = (record_type == tlsrcb_pkg::REC_ALERT);

	// length channel
	assign len_hit  = is_data && ((record_length == tlsrcb_pkg::LEN_ZERO) ||
	                              (record_length == tlsrcb_pkg::LEN_ONE));
	assign len_bit  = (record_length == tlsrcb_pkg::LEN_ONE);
	assign len_next = len_shift_q | ({7'd0, len_bit} << len_cnt_q);
	assign len_done = len_hit && (len_cnt_q == tlsrcb_pkg::LEN_LAST);

	// type channel: stuffed data records and data before the start bit drop out
	assign typ_take = is_alert ||
	                  (is_data && (run_q != tlsrcb_pkg::STUFF_RUN) && (typ_cnt_q != 4'd0));
	assign typ_pos  = 3'(typ_cnt_q - 4'd1);
	assign typ_next = (typ_cnt_q != 4'd0) ? (typ_shift_q | ({7'd0, is_data} << typ_pos))
	                                      : typ_shift_q;
	assign typ_done = typ_take && (typ_cnt_q == tlsrcb_pkg::BYTE_BITS);

	always_comb begin
		res.need_len = len_done;
		res.len_raw  = len_next;
		res.need_typ = typ_done;
		res.typ_raw  = typ_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cnt_q   <= '0;
			len_shift_q <= '0;
			typ_cnt_q   <= '0;
			typ_shift_q <= '0;
			run_q       <= '0;
		end else if (upd) begin
			if (restart) begin
				len_cnt_q   <= '0;
				len_shift_q <= '0;
				typ_cnt_q   <= '0;
				typ_shift_q <= '0;
				run_q       <= '0;
			end else begin
				if (len_hit) begin
					if (len_done) begin
						len_cnt_q   <= '0;
						len_shift_q <= '0;
					end else begin
						len_cnt_q   <= len_cnt_q + 3'd1;
						len_shift_q <= len_next;
					end
				end
				if (is_data) begin
					run_q <= '0;
				end else if (is_alert && (run_q < tlsrcb_pkg::RUN_MAX)) begin
					run_q <= run_q + 3'd1;
				end
				if (typ_take) begin
					if (typ_done) begin
						typ_cnt_q   <= '0;
						typ_shift_q <= '0;
					end else begin
						typ_cnt_q   <= typ_cnt_q + 4'd1;
						typ_shift_q <= typ_next;
					end
				end
			end
		end
	end

endmodule

/* hw/rtl/tlsrcb_chk.sv */
// ----------------------------------------------------------------------------
// tlsrcb_chk
// port-level checks of the tls record covert bit decoder
// ----------------------------------------------------------------------------
`include "tls_record_covert_bit_decoder_defines.svh"

module tlsrcb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a stalled output beat holds
	`TLSRCB_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// a byte without its flag reads as zero
	`TLSRCB_ASSERT_IMPLY(a_len_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata[7:0] == 8'd0)
	`TLSRCB_ASSERT_IMPLY(a_typ_zero, clk, arst_n, m_tvalid && !m_tuser[1], m_tdata[15:8] == 8'd0)

	// one record at a time: not ready right after a beat
	`TLSRCB_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind tls_record_covert_bit_decoder tlsrcb_chk u_chk (.*);

/* dv/tb_tls_record_covert_bit_decoder.sv */
// ----------------------------------------------------------------------------
// tb_tls_record_covert_bit_decoder
// self-checking bench for the record length and content type covert decoders
// ----------------------------------------------------------------------------
// Records are queued by the stimulus process and sent by a driver that adds
// random idle bursts. Each accepted record runs through a local decoder
// that predicts the output beat. A monitor pops the oldest prediction
// for every output beat and compares it field by field. The seed registers
// are rewritten between phases, and only once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb_tls_record_covert_bit_decoder;

	localparam int        PHASE_RECORDS = 300;
	localparam int        SETTLE_CYCLES = 16;      // longer than the slowest record takes
	localparam int        CYCLE_LIMIT   = 400000;
	localparam logic [7:0] HANDSHAKE_TYPE = 8'd22; // neither alert nor data

	typedef struct packed {
		logic        restart;
		logic [7:0]  rtype;
		logic [15:0] rlen;
	} record_t;

	typedef struct packed {
		logic       lvalid;
		logic [7:0] lbyte;
		logic       tvalid;
		logic [7:0] tbyte;
	} decoded_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;   // [7:0] record_type, [23:8] record_length
	logic        s_tuser  = 1'b0; // [0] restart
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // [7:0] length_byte, [15:8] type_byte
	logic [1:0]  m_tuser;         // [0] length_byte_valid, [1] type_byte_valid
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data  = '0;

	tls_record_covert_bit_decoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decoder mirror: seed registers and per-channel bit state
	logic [31:0] len_seed  = '0;
	logic [31:0] typ_seed  = '0;
	logic [31:0] len_gen   = '0;
	logic [31:0] typ_gen   = '0;
	logic [3:0]  len_bits  = '0;
	logic [7:0]  len_sr    = '0;
	logic [3:0]  typ_bits  = '0;  // 0 while hunting for the start bit
	logic [7:0]  typ_sr    = '0;
	logic [2:0]  alert_run = '0;

	record_t  record_q[$];
	decoded_t decoded_q[$];
	decoded_t want;

	int   src_gap   = 0;
	int   sink_gap  = 0;
	bit   idle_on   = 1'b1;
	logic rec_taken = 1'b0;
	int   n_fail    = 0;
	int   cycles    = 0;

	// three rand_r style generator steps
	function automatic logic [31:0] lcg_advance(logic [31:0] x);
		for (int i = 0; i < 3; i++)
			x = x * tlsrcb_pkg::LCG_MUL + tlsrcb_pkg::LCG_ADD;
		return x;
	endfunction

	// one record through both channels, returns the beat it should produce
	function automatic decoded_t decode_record(record_t r);
		decoded_t d;
		logic     take;
		d = '0;
		if (r.restart) begin
			// clear bit state, generators pick up the current seeds
			len_bits  = '0;
			len_sr    = '0;
			typ_bits  = '0;
			typ_sr    = '0;
			alert_run = '0;
			len_gen   = len_seed;
			typ_gen   = typ_seed;
		end else begin
			// length channel: only data records of the two symbol lengths
			if (r.rtype == tlsrcb_pkg::REC_DATA &&
			    (r.rlen == tlsrcb_pkg::LEN_ZERO || r.rlen == tlsrcb_pkg::LEN_ONE)) begin
				len_sr[len_bits[2:0]] = (r.rlen == tlsrcb_pkg::LEN_ONE);
				len_bits = len_bits + 4'd1;
				if (len_bits == tlsrcb_pkg::BYTE_BITS) begin
					len_gen  = lcg_advance(len_gen);
					d.lvalid = 1'b1;
					d.lbyte  = len_sr ^ len_gen[23:16];
					len_bits = '0;
					len_sr   = '0;
				end
			end
			// type channel: alert is 0, data is 1, other types do nothing
			if (r.rtype == tlsrcb_pkg::REC_DATA || r.rtype == tlsrcb_pkg::REC_ALERT) begin
				take = 1'b1;
				if (r.rtype == tlsrcb_pkg::REC_DATA) begin
					// stuffed bit after four alerts, and data while hunting for start
					if (alert_run == tlsrcb_pkg::STUFF_RUN || typ_bits == 4'd0)
						take = 1'b0;
					alert_run = '0;
				end else if (alert_run < tlsrcb_pkg::RUN_MAX) begin
					alert_run = alert_run + 3'd1;
				end
				if (take) begin
					if (typ_bits != 4'd0)
						typ_sr[3'(typ_bits - 4'd1)] = (r.rtype == tlsrcb_pkg::REC_DATA);
					typ_bits = typ_bits + 4'd1;
					if (typ_bits > tlsrcb_pkg::BYTE_BITS) begin
						typ_gen  = lcg_advance(typ_gen);
						d.tvalid = 1'b1;
						d.tbyte  = typ_sr ^ typ_gen[23:16];
						typ_bits = '0;
						typ_sr   = '0;
					end
				end
			end
		end
		return d;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, exp_val);
		n_fail++;
	endtask

	// output check first, then the prediction for the beat taken at this edge
	always @(posedge clk) begin
		rec_taken <= s_tvalid && s_tready;
		if (m_tvalid && m_tready) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("beat with nothing pending", 32'({m_tuser, m_tdata}), 32'd0);
			end else begin
				want = decoded_q.pop_front();
				if (m_tuser[0] !== want.lvalid)
					report_mismatch("length_byte_valid", 32'(m_tuser[0]), 32'(want.lvalid));
				if (m_tdata[7:0] !== want.lbyte)
					report_mismatch("length_byte", 32'(m_tdata[7:0]), 32'(want.lbyte));
				if (m_tuser[1] !== want.tvalid)
					report_mismatch("type_byte_valid", 32'(m_tuser[1]), 32'(want.tvalid));
				if (m_tdata[15:8] !== want.tbyte)
					report_mismatch("type_byte", 32'(m_tdata[15:8]), 32'(want.tbyte));
			end
		end
		if (s_tvalid && s_tready)
			decoded_q.push_back(decode_record({s_tuser, s_tdata[7:0], s_tdata[23:8]}));
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[%0t] timeout, %0d beats still pending", $time, decoded_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// record driver: holds a beat until taken, idle bursts between beats
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || rec_taken)) begin
			if (src_gap != 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (record_q.size() != 0) begin
				record_t r;
				r = record_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= r.restart;
				s_tdata  <= {r.rlen, r.rtype};
				if (idle_on && $urandom_range(0, 3) == 0)
					src_gap = $urandom_range(1, 19);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink side: random back-pressure bursts
	always @(negedge clk) begin
		if (arst_n) begin
			if (sink_gap != 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 4) == 0)
					sink_gap = $urandom_range(1, 19);
			end
		end
	end

	task automatic push_record(logic restart, logic [7:0] rtype, logic [15:0] rlen);
		record_q.push_back({restart, rtype, rlen});
	endtask

	function automatic logic [15:0] symbol_len();
		return ($urandom_range(0, 1) != 0) ? tlsrcb_pkg::LEN_ONE : tlsrcb_pkg::LEN_ZERO;
	endfunction

	// mostly well-formed covert traffic, some stuffing runs, some noise
	task automatic queue_random_records(int count);
		int n;
		int pick;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				push_record(1'b1, 8'($urandom), 16'($urandom));
				n++;
			end else if (pick < 13) begin
				// four alerts then data hits the stuffed-bit rule
				repeat (4) push_record(1'b0, tlsrcb_pkg::REC_ALERT, 16'($urandom));
				push_record(1'b0, tlsrcb_pkg::REC_DATA,
					($urandom_range(0, 3) != 0) ? symbol_len() : 16'($urandom));
				n += 5;
			end else if (pick < 45) begin
				push_record(1'b0, tlsrcb_pkg::REC_DATA, symbol_len());
				n++;
			end else if (pick < 55) begin
				push_record(1'b0, tlsrcb_pkg::REC_DATA,
					($urandom_range(0, 1) != 0) ? 16'($urandom) :
					symbol_len() + 16'($urandom_range(0, 2)) - 16'd1);
				n++;
			end else if (pick < 90) begin
				push_record(1'b0, tlsrcb_pkg::REC_ALERT,
					($urandom_range(0, 3) == 0) ? symbol_len() : 16'($urandom));
				n++;
			end else begin
				push_record(1'b0, 8'($urandom), 16'($urandom));
				n++;
			end
		end
	endtask

	// wait until every record is sent and every beat has come back
	task automatic drain();
		while (record_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(logic idx, logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == tlsrcb_pkg::CFG_LEN_SEED)
			len_seed = val;
		else
			typ_seed = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// new seeds stay parked until the restart below
		write_seed(tlsrcb_pkg::CFG_LEN_SEED, 32'hFFFF_FFFF);
		write_seed(tlsrcb_pkg::CFG_TYP_SEED, 32'h0000_0000);

		// directed: data before any start bit, field extremes, off-symbol lengths
		push_record(1'b0, tlsrcb_pkg::REC_DATA, tlsrcb_pkg::LEN_ZERO);
		push_record(1'b0, 8'h00, 16'h0000);
		push_record(1'b0, 8'hFF, 16'hFFFF);
		push_record(1'b0, tlsrcb_pkg::REC_ALERT, tlsrcb_pkg::LEN_ONE);  // start bit
		push_record(1'b0, tlsrcb_pkg::REC_DATA, tlsrcb_pkg::LEN_ONE);
		repeat (4) push_record(1'b0, tlsrcb_pkg::REC_ALERT, 16'h0000);
		push_record(1'b0, tlsrcb_pkg::REC_DATA, tlsrcb_pkg::LEN_ZERO);  // stuffed, dropped
		// six alerts in a row: run saturates, byte completes, next start bit
		repeat (6) push_record(1'b0, tlsrcb_pkg::REC_ALERT, 16'h0001);
		push_record(1'b0, tlsrcb_pkg::REC_DATA, tlsrcb_pkg::LEN_ONE);   // run past four
		push_record(1'b0, tlsrcb_pkg::REC_DATA, tlsrcb_pkg::LEN_ONE);
		push_record(1'b0, tlsrcb_pkg::REC_DATA, tlsrcb_pkg::LEN_ZERO);
		push_record(1'b0, HANDSHAKE_TYPE, tlsrcb_pkg::LEN_ZERO);        // other type ignored
		push_record(1'b0, tlsrcb_pkg::REC_DATA, tlsrcb_pkg::LEN_ZERO - 16'd1);
		push_record(1'b0, tlsrcb_pkg::REC_DATA, tlsrcb_pkg::LEN_ONE + 16'd1);
		push_record(1'b0, tlsrcb_pkg::REC_DATA, tlsrcb_pkg::LEN_ONE);
		push_record(1'b0, tlsrcb_pkg::REC_DATA, tlsrcb_pkg::LEN_ZERO);  // eighth length bit
		push_record(1'b1, 8'hFF, 16'hFFFF);             // restart, fields ignored
		push_record(1'b1, 8'h00, 16'h0000);
		drain();

		// random phases, one seed pair each, always reloaded by a restart
		write_seed(tlsrcb_pkg::CFG_LEN_SEED, 32'h0000_0000);
		write_seed(tlsrcb_pkg::CFG_TYP_SEED, 32'hFFFF_FFFF);
		push_record(1'b1, tlsrcb_pkg::REC_DATA, tlsrcb_pkg::LEN_ONE);
		queue_random_records(PHASE_RECORDS);
		drain();

		write_seed(tlsrcb_pkg::CFG_LEN_SEED, $urandom);
		write_seed(tlsrcb_pkg::CFG_TYP_SEED, $urandom);
		push_record(1'b1, tlsrcb_pkg::REC_ALERT, tlsrcb_pkg::LEN_ZERO);
		queue_random_records(PHASE_RECORDS);
		drain();

		write_seed(tlsrcb_pkg::CFG_LEN_SEED, 32'h0000_0001);
		write_seed(tlsrcb_pkg::CFG_TYP_SEED, 32'h8000_0000);
		push_record(1'b1, 8'($urandom), 16'($urandom));
		queue_random_records(PHASE_RECORDS);
		drain();

		// closing phase at full rate on both sides
		write_seed(tlsrcb_pkg::CFG_LEN_SEED, $urandom);
		write_seed(tlsrcb_pkg::CFG_TYP_SEED, $urandom);
		idle_on = 1'b0;
		push_record(1'b1, 8'h00, 16'h0000);
		queue_random_records(PHASE_RECORDS);
		drain();

		if (decoded_q.size() != 0)
			report_mismatch("beats never delivered", 32'(decoded_q.size()), 32'd0);
		if (n_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
